[rtl/core/i2cm_pkg.sv]
// Shared types and constants for the I2C register access master.
// Used by the front end, the bus engine and the top level; no dependencies.
package i2cm_pkg;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [15:0] RESET_PHASE_TICKS = 16'd120;
	localparam logic [3:0]  BYTE_BITS         = 4'd8;
	localparam int          MSB               = 7;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  device_address;
		logic [7:0]  register_address;
		logic [7:0]  write_data;
		logic        sda_in;
	} tick_item_t;

	typedef struct packed {
		logic       valid;
		tick_item_t item;
	} queue_head_t;

	typedef enum logic [15:0] {
		PH_IDLE    = 16'h0001,
		PH_ST_A    = 16'h0002,
		PH_ST_B    = 16'h0004,
		PH_ST_C    = 16'h0008,
		PH_WB_LOW  = 16'h0010,
		PH_WB_HIGH = 16'h0020,
		PH_WA_LOW  = 16'h0040,
		PH_WA_HIGH = 16'h0080,
		PH_WA_END  = 16'h0100,
		PH_RB_HIGH = 16'h0200,
		PH_RB_LOW  = 16'h0400,
		PH_RN_LOW  = 16'h0800,
		PH_RN_HIGH = 16'h1000,
		PH_SP_A    = 16'h2000,
		PH_SP_B    = 16'h4000,
		PH_SP_C    = 16'h8000
	} bus_phase_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] read_data;
	} tick_result_t;

endpackage

[rtl/core/i2cm_front.sv]
// Front end: takes tick items, classifies the opcode and queues them.
// Depends on i2cm_pkg.
module i2cm_front #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic [1:0]            opcode,
	input  logic [6:0]            device_address,
	input  logic [7:0]            register_address,
	input  logic [7:0]            write_data,
	input  logic                  sda_in,
	output i2cm_pkg::queue_head_t head,
	input  logic                  pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	i2cm_pkg::tick_item_t mem_q [DEPTH];
	i2cm_pkg::tick_item_t new_item;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 push;
	logic                 do_pop;

	always_comb begin
		case (opcode)
			i2cm_pkg::OP_WRITE: new_item.kind = i2cm_pkg::CMD_WRITE;
			i2cm_pkg::OP_READ:  new_item.kind = i2cm_pkg::CMD_READ;
			default:            new_item.kind = i2cm_pkg::CMD_NONE;
		endcase
		new_item.device_address   = device_address;
		new_item.register_address = register_address;
		new_item.write_data       = write_data;
		new_item.sda_in           = sda_in;
	end

	assign cmd_stall  = (count_q == FULL_CNT);
	assign push       = cmd_valid && !cmd_stall;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/i2cm_back.sv]
// Bus engine: steps the I2C phase sequencer once per queued tick and
// registers the result for the output channel. Depends on i2cm_pkg.
module i2cm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2cm_pkg::queue_head_t head,
	output logic                  pop,
	input  logic [15:0]           phase_ticks,
	output logic                  res_valid,
	input  logic                  res_stall,
	output i2cm_pkg::tick_result_t res
);

	i2cm_pkg::bus_phase_t phase_q, phase_e, phase_d;
	logic [15:0] cnt_q, cnt_e, cnt_d;
	logic [3:0]  bit_q, bit_e, bit_d;
	logic [1:0]  byte_q, byte_e, byte_d;
	logic [7:0]  shift_q, shift_e, shift_d;
	logic [6:0]  dev_q, dev_e;
	logic [7:0]  reg_q, reg_e;
	logic [7:0]  data_q, data_e;
	logic        rd_q, rd_e;
	logic        ack_q, ack_e, ack_d;
	logic [16:0] cnt_inc;
	logic [3:0]  bit_inc;
	logic        last;
	logic        start;
	logic        fire;
	logic        res_valid_q;
	i2cm_pkg::tick_result_t r;
	i2cm_pkg::tick_result_t res_q;

	assign fire  = head.valid && (!res_valid_q || !res_stall);
	assign pop   = fire;
	assign start = (phase_q == i2cm_pkg::PH_IDLE) && (head.item.kind != i2cm_pkg::CMD_NONE);

	always_comb begin
		phase_e = start ? i2cm_pkg::PH_ST_A : phase_q;
		cnt_e   = start ? '0 : cnt_q;
		bit_e   = start ? '0 : bit_q;
		byte_e  = start ? '0 : byte_q;
		shift_e = start ? '0 : shift_q;
		dev_e   = start ? head.item.device_address : dev_q;
		reg_e   = start ? head.item.register_address : reg_q;
		data_e  = start ? head.item.write_data : data_q;
		rd_e    = start ? (head.item.kind == i2cm_pkg::CMD_READ) : rd_q;
		ack_e   = start ? 1'b1 : ack_q;

		cnt_inc = {1'b0, cnt_e} + 17'd1;
		bit_inc = bit_e + 4'd1;
		last    = cnt_inc >= {1'b0, phase_ticks};

		r               = '0;
		r.busy_res      = (phase_e != i2cm_pkg::PH_IDLE);
		case (phase_e)
			i2cm_pkg::PH_ST_B:    r.sda_drive_low = 1'b1;
			i2cm_pkg::PH_ST_C: begin
				r.scl_drive_low = 1'b1;
				r.sda_drive_low = 1'b1;
			end
			i2cm_pkg::PH_WB_LOW: begin
				r.scl_drive_low = 1'b1;
				r.sda_drive_low = !shift_e[i2cm_pkg::MSB];
			end
			i2cm_pkg::PH_WB_HIGH: r.sda_drive_low = !shift_e[i2cm_pkg::MSB];
			i2cm_pkg::PH_WA_LOW,
			i2cm_pkg::PH_WA_END,
			i2cm_pkg::PH_RB_LOW,
			i2cm_pkg::PH_RN_LOW:  r.scl_drive_low = 1'b1;
			i2cm_pkg::PH_SP_A: begin
				r.scl_drive_low = 1'b1;
				r.sda_drive_low = 1'b1;
			end
			i2cm_pkg::PH_SP_B:    r.sda_drive_low = 1'b1;
			default: ;
		endcase

		phase_d = phase_e;
		cnt_d   = cnt_e;
		bit_d   = bit_e;
		byte_d  = byte_e;
		shift_d = shift_e;
		ack_d   = ack_e;
		if (phase_e != i2cm_pkg::PH_IDLE) begin
			if (!last) begin
				cnt_d = cnt_inc[15:0];
			end else begin
				cnt_d = '0;
				case (phase_e)
					i2cm_pkg::PH_ST_A: phase_d = i2cm_pkg::PH_ST_B;
					i2cm_pkg::PH_ST_B: phase_d = i2cm_pkg::PH_ST_C;
					i2cm_pkg::PH_ST_C: begin
						shift_d = {dev_e, (byte_e == 2'd2)};
						bit_d   = '0;
						phase_d = i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_WB_LOW: phase_d = i2cm_pkg::PH_WB_HIGH;
					i2cm_pkg::PH_WB_HIGH: begin
						shift_d = {shift_e[6:0], 1'b0};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= i2cm_pkg::BYTE_BITS) ?
							i2cm_pkg::PH_WA_LOW : i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_WA_LOW: phase_d = i2cm_pkg::PH_WA_HIGH;
					i2cm_pkg::PH_WA_HIGH: begin
						if (head.item.sda_in) begin
							ack_d = 1'b0;
						end
						phase_d = i2cm_pkg::PH_WA_END;
					end
					i2cm_pkg::PH_WA_END: begin
						if (!ack_e) begin
							phase_d = i2cm_pkg::PH_SP_A;
						end else if (byte_e == 2'd0) begin
							byte_d  = 2'd1;
							shift_d = reg_e;
							bit_d   = '0;
							phase_d = i2cm_pkg::PH_WB_LOW;
						end else if (byte_e == 2'd1) begin
							byte_d = 2'd2;
							if (rd_e) begin
								phase_d = i2cm_pkg::PH_ST_A;
							end else begin
								shift_d = data_e;
								bit_d   = '0;
								phase_d = i2cm_pkg::PH_WB_LOW;
							end
						end else if (byte_e == 2'd2 && rd_e) begin
							shift_d = '0;
							bit_d   = '0;
							phase_d = i2cm_pkg::PH_RB_HIGH;
						end else begin
							phase_d = i2cm_pkg::PH_SP_A;
						end
					end
					i2cm_pkg::PH_RB_HIGH: begin
						shift_d = {shift_e[6:0], head.item.sda_in};
						phase_d = i2cm_pkg::PH_RB_LOW;
					end
					i2cm_pkg::PH_RB_LOW: begin
						bit_d   = bit_inc;
						phase_d = (bit_inc >= i2cm_pkg::BYTE_BITS) ?
							i2cm_pkg::PH_RN_LOW : i2cm_pkg::PH_RB_HIGH;
					end
					i2cm_pkg::PH_RN_LOW:  phase_d = i2cm_pkg::PH_RN_HIGH;
					i2cm_pkg::PH_RN_HIGH: phase_d = i2cm_pkg::PH_SP_A;
					i2cm_pkg::PH_SP_A:    phase_d = i2cm_pkg::PH_SP_B;
					i2cm_pkg::PH_SP_B:    phase_d = i2cm_pkg::PH_SP_C;
					i2cm_pkg::PH_SP_C: begin
						r.done_res  = 1'b1;
						r.ack_ok    = ack_e;
						r.read_data = (rd_e && ack_e) ? shift_e : '0;
						phase_d     = i2cm_pkg::PH_IDLE;
					end
					default: phase_d = i2cm_pkg::PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			cnt_q       <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			shift_q     <= '0;
			dev_q       <= '0;
			reg_q       <= '0;
			data_q      <= '0;
			rd_q        <= 1'b0;
			ack_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				bit_q   <= bit_d;
				byte_q  <= byte_d;
				shift_q <= shift_d;
				dev_q   <= dev_e;
				reg_q   <= reg_e;
				data_q  <= data_e;
				rd_q    <= rd_e;
				ack_q   <= ack_d;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= r;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/i2c_master_register_access.sv]
// Top level of the I2C register access master: front end queue, bus engine
// and the phase_ticks register. Depends on i2cm_pkg, i2cm_front, i2cm_back.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall) carries one bus timer tick per
//   transfer: opcode, device_address, register_address, write_data, sda_in.
//   An opcode of write or read starts a transaction when the engine is idle
//   and is ignored while busy.
//   Result channel (res_valid / res_stall) returns exactly one transfer per
//   tick: SCL/SDA pull-low controls, busy_res, done_res, ack_ok, read_data.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes phase_ticks;
//   cfg_ready is always high. Write it only while idle.
//   With an empty queue an accepted tick is first written into the queue; its
//   result is then registered and held on the result ports.
//   Throughput: one tick per cycle while no stalled result is held; the
//   sequencer state register is the only loop and steps once per popped tick.
//   When res_stall is high the result holds; the queue of QUEUE_DEPTH ticks
//   fills and then cmd_stall rises.
//   Reset empties the queue, drops the result, returns the engine to idle and
//   sets phase_ticks to 120.
module i2c_master_register_access #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  opcode,
	input  logic [6:0]  device_address,
	input  logic [7:0]  register_address,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl_drive_low,
	output logic        sda_drive_low,
	output logic        busy_res,
	output logic        done_res,
	output logic        ack_ok,
	output logic [7:0]  read_data
);

	i2cm_pkg::queue_head_t  head;
	i2cm_pkg::tick_result_t res;
	logic                   pop;
	logic [15:0]            phase_ticks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::RESET_PHASE_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	i2cm_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.opcode           (opcode),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.head             (head),
		.pop              (pop)
	);

	i2cm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.phase_ticks (phase_ticks_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	assign scl_drive_low = res.scl_drive_low;
	assign sda_drive_low = res.sda_drive_low;
	assign busy_res      = res.busy_res;
	assign done_res      = res.done_res;
	assign ack_ok        = res.ack_ok;
	assign read_data     = res.read_data;

endmodule

[rtl/core/i2cm_checker.sv]
// Port-level checks for the I2C register access master, bound to the top.
// Depends only on the top level's ports.
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        scl_drive_low,
	input logic        sda_drive_low,
	input logic        busy_res,
	input logic        done_res,
	input logic        ack_ok,
	input logic [7:0]  read_data
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> busy_res && !scl_drive_low && !sda_drive_low)
		else $error("done without busy or with lines driven");

	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> !scl_drive_low && !sda_drive_low && !done_res)
		else $error("lines driven while idle");

	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> !ack_ok && (read_data == 8'd0))
		else $error("ack or data without done");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(scl_drive_low) &&
		$stable(sda_drive_low) && $stable(busy_res) && $stable(done_res) &&
		$stable(ack_ok) && $stable(read_data))
		else $error("stalled result changed");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.scl_drive_low (scl_drive_low),
	.sda_drive_low (sda_drive_low),
	.busy_res      (busy_res),
	.done_res      (done_res),
	.ack_ok        (ack_ok),
	.read_data     (read_data)
);

[bench/i2c_master_register_access_tb.sv]
// Testbench for i2c_master_register_access: drives one bus tick per transfer,
// plays the target on sda_in, and checks every result tick against a bus predictor.
// Depends on i2cm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module i2c_master_register_access_tb;

	localparam logic [1:0] OP_NONE     = i2cm_pkg::OP_NONE;
	localparam logic [1:0] OP_WRITE    = i2cm_pkg::OP_WRITE;
	localparam logic [1:0] OP_READ     = i2cm_pkg::OP_READ;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         RANDOM_TICKS = 150;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         PRINT_CAP    = 40;

	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] dev;
		logic [7:0] reg_addr;
		logic [7:0] wdata;
		logic       sda;
	} bus_tick_t;

	typedef struct packed {
		logic [15:0] ticks;
		logic [1:0]  op;
		logic [6:0]  dev;
		logic [7:0]  reg_addr;
		logic [7:0]  wdata;
		logic [7:0]  rbyte;
		logic [1:0]  nack_at;
		logic [7:0]  idle_n;
		logic        typed;
		logic        exp_ack;
		logic [7:0]  exp_rd;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  opcode = OP_NONE;
	logic [6:0]  device_address = '0;
	logic [7:0]  register_address = '0;
	logic [7:0]  write_data = '0;
	logic        sda_in = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        scl_drive_low;
	logic        sda_drive_low;
	logic        busy_res;
	logic        done_res;
	logic        ack_ok;
	logic [7:0]  read_data;

	i2c_master_register_access dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.opcode           (opcode),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.scl_drive_low    (scl_drive_low),
		.sda_drive_low    (sda_drive_low),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.ack_ok           (ack_ok),
		.read_data        (read_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	i2cm_pkg::bus_phase_t phase = i2cm_pkg::PH_IDLE;
	logic [15:0] ticks_cfg = i2cm_pkg::RESET_PHASE_TICKS;
	logic [15:0] phase_cnt = '0;
	logic [3:0]  bit_cnt = '0;
	logic [1:0]  byte_cnt = '0;
	logic [7:0]  shreg = '0;
	logic [6:0]  cmd_dev = '0;
	logic [7:0]  cmd_reg = '0;
	logic [7:0]  cmd_wdata = '0;
	logic        rd_cmd = 1'b0;
	logic        acked = 1'b1;

	// target behavior for the transfer in flight
	logic [1:0]  nack_plan = '0;
	logic [7:0]  read_plan = '0;
	logic        typed_on = 1'b0;
	logic        typed_ack = 1'b0;
	logic [7:0]  typed_rd = '0;

	i2cm_pkg::tick_result_t expected_bus[$];
	int          mismatches = 0;
	int          ticks_sent = 0;
	int          dones = 0;
	int          nack_dones = 0;
	int          cfg_writes = 0;
	int          cycle_count = 0;
	int          holds_asked = 0;
	bit          calm = 1'b0;

	plan_row_t plan [13] = '{
		'{16'd120,   OP_NONE,   7'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'd3, 1'b0, 1'b0, 8'h00},
		'{16'd1,     OP_WRITE,  7'h7F, 8'hFF, 8'hFF, 8'h00, 2'd1, 8'd0, 1'b1, 1'b0, 8'h00},
		'{16'd0,     OP_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'd4, 1'b0, 1'b0, 8'h00},
		'{16'd0,     OP_WRITE,  7'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'd0, 1'b1, 1'b1, 8'h00},
		'{16'd1,     OP_READ,   7'h7F, 8'hFF, 8'h00, 8'hFF, 2'd0, 8'd0, 1'b1, 1'b1, 8'hFF},
		'{16'd1,     OP_READ,   7'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'd0, 1'b1, 1'b1, 8'h00},
		'{16'd1,     OP_READ,   7'h55, 8'hAA, 8'h00, 8'hA5, 2'd3, 8'd0, 1'b1, 1'b0, 8'h00},
		'{16'd2,     OP_WRITE,  7'h2A, 8'h5A, 8'hC3, 8'h00, 2'd2, 8'd0, 1'b1, 1'b0, 8'h00},
		'{16'd2,     OP_WRITE,  7'h15, 8'h81, 8'h7E, 8'h00, 2'd3, 8'd0, 1'b1, 1'b0, 8'h00},
		'{16'd3,     OP_READ,   7'h33, 8'h0F, 8'h00, 8'h3C, 2'd2, 8'd0, 1'b1, 1'b0, 8'h00},
		'{16'd65535, OP_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'd5, 1'b0, 1'b0, 8'h00},
		'{16'd1,     OP_WRITE,  7'h6B, 8'h96, 8'h5A, 8'h00, 2'd0, 8'd0, 1'b0, 1'b0, 8'h00},
		'{16'd1,     OP_READ,   7'h2C, 8'h71, 8'h00, 8'hC8, 2'd1, 8'd0, 1'b1, 1'b0, 8'h00}
	};

	function automatic void load_byte(input logic [7:0] v);
		shreg = v;
		bit_cnt = '0;
		phase = i2cm_pkg::PH_WB_LOW;
	endfunction

	function automatic i2cm_pkg::tick_result_t predict_bus_tick(input bus_tick_t t);
		i2cm_pkg::tick_result_t r;
		int limit;
		r = '0;
		limit = (ticks_cfg == 16'd0) ? 1 : int'(ticks_cfg);
		if (phase == i2cm_pkg::PH_IDLE && (t.opcode == OP_WRITE || t.opcode == OP_READ)) begin
			cmd_dev = t.dev;
			cmd_reg = t.reg_addr;
			cmd_wdata = t.wdata;
			rd_cmd = (t.opcode == OP_READ);
			acked = 1'b1;
			byte_cnt = '0;
			bit_cnt = '0;
			shreg = '0;
			phase_cnt = '0;
			phase = i2cm_pkg::PH_ST_A;
		end
		case (phase)
			i2cm_pkg::PH_ST_B, i2cm_pkg::PH_SP_B: r.sda_drive_low = 1'b1;
			i2cm_pkg::PH_ST_C, i2cm_pkg::PH_SP_A: begin
				r.scl_drive_low = 1'b1;
				r.sda_drive_low = 1'b1;
			end
			i2cm_pkg::PH_WB_LOW: begin
				r.scl_drive_low = 1'b1;
				r.sda_drive_low = ~shreg[i2cm_pkg::MSB];
			end
			i2cm_pkg::PH_WB_HIGH: r.sda_drive_low = ~shreg[i2cm_pkg::MSB];
			i2cm_pkg::PH_WA_LOW, i2cm_pkg::PH_WA_END,
			i2cm_pkg::PH_RB_LOW, i2cm_pkg::PH_RN_LOW: r.scl_drive_low = 1'b1;
			default: ;
		endcase
		r.busy_res = (phase != i2cm_pkg::PH_IDLE);
		if (phase != i2cm_pkg::PH_IDLE) begin
			if (int'(phase_cnt) + 1 < limit) begin
				phase_cnt++;
			end else begin
				phase_cnt = '0;
				case (phase)
					i2cm_pkg::PH_ST_A: phase = i2cm_pkg::PH_ST_B;
					i2cm_pkg::PH_ST_B: phase = i2cm_pkg::PH_ST_C;
					i2cm_pkg::PH_ST_C: load_byte({cmd_dev, byte_cnt == 2'd2});
					i2cm_pkg::PH_WB_LOW: phase = i2cm_pkg::PH_WB_HIGH;
					i2cm_pkg::PH_WB_HIGH: begin
						shreg = shreg << 1;
						bit_cnt++;
						phase = (bit_cnt >= i2cm_pkg::BYTE_BITS) ?
							i2cm_pkg::PH_WA_LOW : i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_WA_LOW: phase = i2cm_pkg::PH_WA_HIGH;
					i2cm_pkg::PH_WA_HIGH: begin
						if (t.sda)
							acked = 1'b0;
						phase = i2cm_pkg::PH_WA_END;
					end
					i2cm_pkg::PH_WA_END: begin
						if (!acked) begin
							phase = i2cm_pkg::PH_SP_A;
						end else if (byte_cnt == 2'd0) begin
							byte_cnt = 2'd1;
							load_byte(cmd_reg);
						end else if (byte_cnt == 2'd1) begin
							byte_cnt = 2'd2;
							if (rd_cmd)
								phase = i2cm_pkg::PH_ST_A;
							else
								load_byte(cmd_wdata);
						end else if (rd_cmd) begin
							shreg = '0;
							bit_cnt = '0;
							phase = i2cm_pkg::PH_RB_HIGH;
						end else begin
							phase = i2cm_pkg::PH_SP_A;
						end
					end
					i2cm_pkg::PH_RB_HIGH: begin
						shreg = {shreg[6:0], t.sda};
						phase = i2cm_pkg::PH_RB_LOW;
					end
					i2cm_pkg::PH_RB_LOW: begin
						bit_cnt++;
						phase = (bit_cnt >= i2cm_pkg::BYTE_BITS) ?
							i2cm_pkg::PH_RN_LOW : i2cm_pkg::PH_RB_HIGH;
					end
					i2cm_pkg::PH_RN_LOW: phase = i2cm_pkg::PH_RN_HIGH;
					i2cm_pkg::PH_RN_HIGH: phase = i2cm_pkg::PH_SP_A;
					i2cm_pkg::PH_SP_A: phase = i2cm_pkg::PH_SP_B;
					i2cm_pkg::PH_SP_B: phase = i2cm_pkg::PH_SP_C;
					i2cm_pkg::PH_SP_C: begin
						r.done_res = 1'b1;
						r.ack_ok = acked;
						r.read_data = (rd_cmd && acked) ? shreg : 8'h00;
						phase = i2cm_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	// ACK or NACK at the planned byte, data bits during reads, noise elsewhere
	function automatic logic target_sda();
		if (phase == i2cm_pkg::PH_WA_HIGH)
			return nack_plan == byte_cnt + 2'd1;
		if (phase == i2cm_pkg::PH_RB_HIGH)
			return read_plan[3'd7 - bit_cnt[2:0]];
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic bus_tick_t random_tick();
		bus_tick_t t;
		t.opcode = 2'($urandom_range(0, 3));
		t.dev = 7'($urandom);
		t.reg_addr = 8'($urandom);
		t.wdata = 8'($urandom);
		t.sda = target_sda();
		return t;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic send_tick(input bus_tick_t t);
		i2cm_pkg::tick_result_t r;
		cmd_valid <= 1'b1;
		opcode <= t.opcode;
		device_address <= t.dev;
		register_address <= t.reg_addr;
		write_data <= t.wdata;
		sda_in <= t.sda;
		do @(posedge clk); while (cmd_stall);
		r = predict_bus_tick(t);
		if (r.done_res) begin
			if (typed_on) begin
				r.ack_ok = typed_ack;
				r.read_data = typed_rd;
			end
			dones++;
			if (!r.ack_ok)
				nack_dones++;
		end
		expected_bus.push_back(r);
		ticks_sent++;
		if (!calm && $urandom_range(0, 9) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (expected_bus.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_phase_ticks(input logic [15:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ticks_cfg = v;
		cfg_writes++;
	endtask

	task automatic run_idle(input int n, input logic [1:0] op);
		bus_tick_t t;
		for (int k = 0; k < n; k++) begin
			t = random_tick();
			t.opcode = op;
			send_tick(t);
		end
	endtask

	task automatic run_transfer(input bus_tick_t first, input logic [1:0] nack,
			input logic [7:0] rbyte, input logic typed, input logic exp_ack,
			input logic [7:0] exp_rd, input int pause_at);
		bus_tick_t t;
		int k;
		nack_plan = nack;
		read_plan = rbyte;
		typed_on = typed;
		typed_ack = exp_ack;
		typed_rd = exp_rd;
		t = first;
		t.sda = target_sda();
		k = 0;
		do begin
			send_tick(t);
			if (k == pause_at)
				drain_results();
			k++;
			t = random_tick();
		end while (phase != i2cm_pkg::PH_IDLE);
		typed_on = 1'b0;
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// receiver side: random stall bursts plus requested long hold-offs
	initial begin : result_stall
		int holds_served;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		i2cm_pkg::tick_result_t seen, want;
		if (arst_n && res_valid && !res_stall) begin
			seen = {scl_drive_low, sda_drive_low, busy_res, done_res, ack_ok, read_data};
			if (expected_bus.size() == 0) begin
				note_mismatch("result transfer with nothing expected", seen, 0);
			end else begin
				want = expected_bus.pop_front();
				if (seen.scl_drive_low !== want.scl_drive_low)
					note_mismatch("scl_drive_low", seen.scl_drive_low, want.scl_drive_low);
				if (seen.sda_drive_low !== want.sda_drive_low)
					note_mismatch("sda_drive_low", seen.sda_drive_low, want.sda_drive_low);
				if (seen.busy_res !== want.busy_res)
					note_mismatch("busy_res", seen.busy_res, want.busy_res);
				if (seen.done_res !== want.done_res)
					note_mismatch("done_res", seen.done_res, want.done_res);
				if (seen.ack_ok !== want.ack_ok)
					note_mismatch("ack_ok", seen.ack_ok, want.ack_ok);
				if (seen.read_data !== want.read_data)
					note_mismatch("read_data", seen.read_data, want.read_data);
			end
		end
	end

	initial begin : stimulus
		bus_tick_t t;
		logic [1:0] nack;
		int mark;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].ticks != ticks_cfg)
				set_phase_ticks(plan[i].ticks);
			if (plan[i].op == OP_WRITE || plan[i].op == OP_READ) begin
				t = '{plan[i].op, plan[i].dev, plan[i].reg_addr, plan[i].wdata, 1'b0};
				run_transfer(t, plan[i].nack_at, plan[i].rbyte, plan[i].typed,
					plan[i].exp_ack, plan[i].exp_rd, -1);
			end else begin
				run_idle(plan[i].idle_n, plan[i].op);
			end
		end

		mark = ticks_sent;
		while (ticks_sent - mark < RANDOM_TICKS) begin
			if (ticks_sent - mark > RANDOM_TICKS - 100)
				calm = 1'b1;
			if (!held) begin
				held = 1'b1;
				holds_asked++;
			end
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: set_phase_ticks(16'd0);
					4: set_phase_ticks(16'd2);
					5: set_phase_ticks(16'd3);
					default: set_phase_ticks(16'd1);
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				run_idle($urandom_range(1, 3), $urandom_range(0, 1) ? OP_NONE : OP_UNUSED);
			end else begin
				t = random_tick();
				t.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
				nack = ($urandom_range(0, 9) < 7) ? 2'd0 : 2'($urandom_range(1, 3));
				run_transfer(t, nack, 8'($urandom), 1'b0, 1'b0, 8'h00,
					paused ? -1 : $urandom_range(5, 40));
				paused = 1'b1;
			end
		end

		calm = 1'b1;
		cmd_valid <= 1'b0;
		while (expected_bus.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d bus ticks and %0d finished transactions, %0d by a NACK.",
			ticks_sent, dones, nack_dones);
		$display("Phase length was set %0d times (0, 1 and 65535 among them), long holds.",
			cfg_writes);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
